// ===== hw/rtl/nlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlp_pkg
// Types, character codes and digit decoding for the numeric literal parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

    // Parse phase of the literal being read
    typedef enum logic [2:0] {
        PH_START = 3'd0,  // start of literal
        PH_SIGN  = 3'd1,  // after '-'
        PH_ZERO  = 3'd2,  // after a leading '0'
        PH_DEC   = 3'd3,  // decimal digits
        PH_HEXP  = 3'd4,  // after "0x"
        PH_HEX   = 3'd5,  // hex digits
        PH_BINP  = 3'd6,  // after "0b"
        PH_BIN   = 3'd7   // binary digits
    } t_phase;

    // Form of the literal recognised so far
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } t_radix;

    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
    localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CH_LX    = 8'h78;  // 'x'

    // Decode a hex digit: bit 4 flags a legal digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            res = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/numeric_literal_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_parser_unit
// Parses decimal, 0x hex and 0b binary number literals one character a request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one ASCII character per
//   request, with i_last_char marking the final character of a literal.
//   Output channel (o_out_valid / i_out_ready) carries one result per literal:
//   the signed value (0 when invalid), the valid flag, the radix seen and the
//   overflow flag. Characters other than the last produce no result.
//   Path: a request taken sits in the input register; when it advances it is
//   folded into the parse state and, if last, its result is loaded into the
//   result register. Throughput: one character per cycle, set by the single
//   shift-add that folds a digit into the accumulator between the input and
//   result registers, except while a last character waits on a held result.
//   Stall: while a result waits, non-last characters keep flowing; a last
//   character holds in the input register until the result slot frees.
//   Reset: clears both registers' valid bits and returns the parse state to
//   the start of a literal with a zero accumulator.
//   After each result the parse state returns to its reset values.
// ----------------------------------------------------------------------------
module numeric_literal_parser_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_char_code,
    input  logic                  i_last_char,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_value,
    output logic                  o_valid_res,
    output logic [1:0]            o_radix_kind,
    output logic                  o_overflow
);
    import nlp_pkg::*;

    // Fold width: acc*16 + 15 always fits in four more bits
    localparam int SW = VALUE_BITS + 4;

    // Input register
    logic                  r_in_valid;
    logic [7:0]            r_char;
    logic                  r_last;

    // Parse state
    t_phase                r_phase,    n_phase;
    logic [VALUE_BITS-1:0] r_acc,      n_acc;
    logic                  r_neg,      n_neg;
    t_radix                r_radix,    n_radix;
    logic                  r_err,      n_err;
    logic                  r_ovf,      n_ovf;

    // Result register
    logic                  r_out_valid;
    logic signed [31:0]    r_value,    n_value;
    logic                  r_valid_res, n_valid_res;
    t_radix                r_radix_out;
    logic                  r_ovf_out,  n_ovf_out;

    logic                  adv;
    logic                  is_dec;
    logic [4:0]            hex_dec;
    logic                  want_fold;
    logic [1:0]            fold_sel;   // 0 decimal, 1 hex, 2 binary
    logic [3:0]            fold_d;
    logic [SW-1:0]         acc_ext;
    logic [SW-1:0]         prod;
    logic [SW-1:0]         fold_sum;
    logic signed [VALUE_BITS-1:0] v_s;

    // Advance when a character is held and its result (if any) has room
    assign adv        = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    assign is_dec  = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign hex_dec = hex_digit(r_char);

    // Single digit fold: acc*radix + d, with radix chosen by shifts
    assign acc_ext = SW'(r_acc);
    always_comb begin
        unique case (fold_sel)
            2'd1:    prod = acc_ext << 4;
            2'd2:    prod = acc_ext << 1;
            default: prod = (acc_ext << 3) + (acc_ext << 1);
        endcase
    end
    assign fold_sum = prod + SW'(fold_d);

    // Character step
    always_comb begin
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_radix   = r_radix;
        n_err     = r_err;
        want_fold = 1'b0;
        fold_sel  = 2'd0;
        fold_d    = r_char[3:0];

        if (!r_err) begin
            unique case (r_phase)
                PH_START: begin
                    if (r_char == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end else if (r_char == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else if (is_dec) begin
                        want_fold = 1'b1;
                        n_phase   = PH_DEC;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_SIGN: begin
                    if (r_char == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else if (is_dec) begin
                        want_fold = 1'b1;
                        n_phase   = PH_DEC;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (r_char == CH_LX) begin
                        n_radix = RADIX_HEX;
                        n_phase = PH_HEXP;
                    end else if (r_char == CH_LB) begin
                        n_radix = RADIX_BIN;
                        // negative binary is not a legal form
                        if (r_neg) n_err = 1'b1;
                        else       n_phase = PH_BINP;
                    end else if (is_dec) begin
                        want_fold = 1'b1;
                        n_phase   = PH_DEC;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (is_dec) want_fold = 1'b1;
                    else        n_err     = 1'b1;
                end
                PH_HEXP, PH_HEX: begin
                    fold_sel = 2'd1;
                    fold_d   = hex_dec[3:0];
                    if (hex_dec[4]) begin
                        want_fold = 1'b1;
                        n_phase   = PH_HEX;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    fold_sel = 2'd2;
                    if (r_char == CH_ZERO || r_char == CH_ONE) begin
                        want_fold = 1'b1;
                        n_phase   = PH_BIN;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            endcase
        end

        n_acc = want_fold ? fold_sum[VALUE_BITS-1:0] : r_acc;
        // overflow when anything spills above the value width
        n_ovf = r_ovf || (want_fold && (fold_sum[SW-1:VALUE_BITS] != '0));

        n_valid_res = !n_err && (n_phase == PH_ZERO || n_phase == PH_DEC ||
                                 n_phase == PH_HEX  || n_phase == PH_BIN);
        v_s       = n_neg ? $signed(-n_acc) : $signed(n_acc);
        // sign-extend (or cut) the accumulator to the 32-bit result
        n_value   = n_valid_res ? 32'(v_s) : '0;
        n_ovf_out = n_valid_res && n_ovf;
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_START;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_radix     <= RADIX_DEC;
            r_err       <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            // take a new request or drop the one just advanced
            if (o_in_ready) r_in_valid <= i_in_valid;
            else if (adv)   r_in_valid <= 1'b0;

            if (adv && r_last)                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            if (adv) begin
                if (r_last) begin
                    // literal finished: back to the start
                    r_phase <= PH_START;
                    r_acc   <= '0;
                    r_neg   <= 1'b0;
                    r_radix <= RADIX_DEC;
                    r_err   <= 1'b0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_acc   <= n_acc;
                    r_neg   <= n_neg;
                    r_radix <= n_radix;
                    r_err   <= n_err;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
            r_last <= i_last_char;
        end
        if (adv && r_last) begin
            r_value     <= n_value;
            r_valid_res <= n_valid_res;
            r_radix_out <= n_radix;
            r_ovf_out   <= n_ovf_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_valid_res  = r_valid_res;
    assign o_radix_kind = r_radix_out;
    assign o_overflow   = r_ovf_out;

    // Assertions
    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_valid_res) |-> (r_value == '0 && !r_ovf_out))
        else $error("invalid literal result carries a value or overflow");

    a_reset_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_last) |=> (r_phase == PH_START && r_acc == '0 && !r_err))
        else $error("parse state not cleared after a literal ended");

    a_last_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_last && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("last character advanced over a waiting result");

endmodule

// ===== verif/numeric_literal_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_parser_unit_tb
// Self-checking bench for the numeric literal parser: decimal, hex and binary
// literals are streamed one character per request, and every result is
// compared with a cycle-free prediction of the parse held in a scoreboard.
// ----------------------------------------------------------------------------

module numeric_literal_parser_unit_tb;

    import nlp_pkg::*;

    // One predicted result of a literal
    typedef struct {
        logic signed [31:0] value;
        logic               valid_res;
        t_radix             radix_kind;
        logic               overflow;
    } t_literal_result;

    class literal_scoreboard #(int WIDTH = 32);

        localparam bit [63:0] MAG_MASK = (64'd2 << (WIDTH - 1)) - 64'd1;

        // Parse state of the literal in flight
        t_phase    cur_phase;
        bit [63:0] magnitude;
        bit        minus_seen;
        t_radix    form_seen;
        bit        junk_seen;
        bit        wrapped;

        t_literal_result pending_results[$];

        int errors;
        int n_results;
        int n_valid;
        int n_ovf;
        int n_hex;
        int n_bin;

        function new();
            errors    = 0;
            n_results = 0;
            n_valid   = 0;
            n_ovf     = 0;
            n_hex     = 0;
            n_bin     = 0;
            restart();
        endfunction

        function void restart();
            cur_phase  = PH_START;
            magnitude  = 64'd0;
            minus_seen = 1'b0;
            form_seen  = RADIX_DEC;
            junk_seen  = 1'b0;
            wrapped    = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        function void shift_in_digit(int unsigned radix, int unsigned d);
            if (magnitude > (MAG_MASK - 64'(d)) / 64'(radix)) begin
                wrapped = 1'b1;
            end
            magnitude = (magnitude * 64'(radix) + 64'(d)) & MAG_MASK;
        endfunction

        function int hex_value(bit [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
            if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
            if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
            return -1;
        endfunction

        function void absorb_char(bit [7:0] c);
            bit is_dec;
            int h;
            is_dec = (c >= CH_ZERO && c <= CH_NINE);
            case (cur_phase)
                PH_START: begin
                    if (c == CH_MINUS) begin
                        minus_seen = 1'b1;
                        cur_phase  = PH_SIGN;
                    end else if (c == CH_ZERO) begin
                        cur_phase = PH_ZERO;
                    end else if (is_dec) begin
                        shift_in_digit(10, c - CH_ZERO);
                        cur_phase = PH_DEC;
                    end else begin
                        junk_seen = 1'b1;
                    end
                end
                PH_SIGN: begin
                    if (c == CH_ZERO) begin
                        cur_phase = PH_ZERO;
                    end else if (is_dec) begin
                        shift_in_digit(10, c - CH_ZERO);
                        cur_phase = PH_DEC;
                    end else begin
                        junk_seen = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (c == CH_LX) begin
                        form_seen = RADIX_HEX;
                        cur_phase = PH_HEXP;
                    end else if (c == CH_LB) begin
                        form_seen = RADIX_BIN;
                        if (minus_seen) junk_seen = 1'b1;
                        else cur_phase = PH_BINP;
                    end else if (is_dec) begin
                        shift_in_digit(10, c - CH_ZERO);
                        cur_phase = PH_DEC;
                    end else begin
                        junk_seen = 1'b1;
                    end
                end
                PH_DEC: begin
                    if (is_dec) shift_in_digit(10, c - CH_ZERO);
                    else junk_seen = 1'b1;
                end
                PH_HEXP, PH_HEX: begin
                    h = hex_value(c);
                    if (h >= 0) begin
                        shift_in_digit(16, h);
                        cur_phase = PH_HEX;
                    end else begin
                        junk_seen = 1'b1;
                    end
                end
                default: begin
                    if (c == CH_ZERO || c == CH_ONE) begin
                        shift_in_digit(2, c - CH_ZERO);
                        cur_phase = PH_BIN;
                    end else begin
                        junk_seen = 1'b1;
                    end
                end
            endcase
        endfunction

        // Fold an accepted character in; on the last one, queue the literal's result
        function void note_request(bit [7:0] c, bit last);
            t_literal_result r;
            bit [63:0] v;
            bit ok;
            if (!junk_seen) absorb_char(c);
            if (last) begin
                ok = !junk_seen && (cur_phase == PH_ZERO || cur_phase == PH_DEC ||
                                    cur_phase == PH_HEX || cur_phase == PH_BIN);
                v = 64'd0;
                if (ok) begin
                    v = minus_seen ? ((64'd0 - magnitude) & MAG_MASK) : magnitude;
                    if (v[WIDTH-1]) v = v | ~MAG_MASK;
                end
                r.value      = v[31:0];
                r.valid_res  = ok;
                r.radix_kind = form_seen;
                r.overflow   = ok && wrapped;
                pending_results.push_back(r);
                n_results++;
                if (ok) n_valid++;
                if (r.overflow) n_ovf++;
                if (form_seen == RADIX_HEX) n_hex++;
                if (form_seen == RADIX_BIN) n_bin++;
                restart();
            end
        endfunction

        task check_result(logic signed [31:0] value, logic valid_res, logic [1:0] radix_kind,
                          logic overflow);
            t_literal_result e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result value=%0d valid=%0b", value, valid_res));
            end else begin
                e = pending_results.pop_front();
                if (value !== e.value)
                    report($sformatf("value %0d, expected %0d", value, e.value));
                if (valid_res !== e.valid_res)
                    report($sformatf("valid_res %0b, expected %0b", valid_res, e.valid_res));
                if (radix_kind !== e.radix_kind)
                    report($sformatf("radix_kind %0d, expected %0d", radix_kind,
                                     e.radix_kind));
                if (overflow !== e.overflow)
                    report($sformatf("overflow %0b, expected %0b", overflow, e.overflow));
            end
        endtask

    endclass

    localparam int VALUE_BITS      = 32;
    localparam int RANDOM_CHARS    = 1600;
    localparam int HOLD_OFF_AT     = 500;   // random characters before the long stall
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;

    // Upper-case marks that must not be taken as prefixes
    localparam logic [7:0] CH_UX = 8'h58;  // 'X'
    localparam logic [7:0] CH_UB = 8'h42;  // 'B'

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_stall_mode;
    typedef enum int {LF_DEC, LF_HEX, LF_BIN, LF_NOISE} t_lit_form;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_char_code = 8'd0;
    logic               i_last_char = 1'b0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_value;
    logic               o_valid_res;
    logic [1:0]         o_radix_kind;
    logic               o_overflow;

    logic hold_off_go = 1'b0;

    literal_scoreboard #(VALUE_BITS) sb;

    bit [7:0] text_q[$];   // characters of the literal about to be sent
    int       burst_left  = 0;
    int       chars_sent  = 0;
    int       in_stalls   = 0;

    numeric_literal_parser_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_valid_res (o_valid_res),
        .o_radix_kind(o_radix_kind),
        .o_overflow  (o_overflow)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake locks up
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Monitors: sample at the edge, so both see the values the block saw
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_request(i_char_code, i_last_char);
        end
        if (i_rst_n && i_in_valid && !o_in_ready) begin
            in_stalls++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_value, o_valid_res, o_radix_kind, o_overflow);
        end
    end

    // Receiver: switch to a randomly chosen stall pattern after a random run; once asked,
    // hold off for a long stretch so the block backs up into its input.
    initial begin : result_sink
        t_stall_mode mode;
        int          mode_left;
        int          held;
        mode      = RX_OPEN;
        mode_left = 0;
        held      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_go && held < HOLD_OFF_CYCLES) begin
                held++;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    // Offer one character and hold it until taken; gaps fall between bursts
    task automatic send_char(input bit [7:0] c, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[k]) send_char(text_q[k], k == text_q.size() - 1);
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
        send_text();
    endtask

    // Build a random literal: mostly well-formed, some noise, a tenth corrupted
    task automatic make_literal();
        t_lit_form form;
        int        sel;
        int        ndig;
        int        d;
        int        pos;
        text_q.delete();
        sel  = $urandom_range(0, 9);
        form = (sel < 3) ? LF_DEC : (sel < 6) ? LF_HEX : (sel < 9) ? LF_BIN : LF_NOISE;
        case (form)
            LF_DEC: begin
                if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
                ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
                                                   : $urandom_range(0, 6);
                if (ndig == 0 && text_q.size() == 0) ndig = 1;
                repeat (ndig) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            LF_HEX: begin
                if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
                text_q.push_back(CH_ZERO);
                text_q.push_back(CH_LX);
                ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11)
                                                   : $urandom_range(1, 8);
                repeat (ndig) begin
                    d = $urandom_range(0, 15);
                    if (d < 10) text_q.push_back(8'(CH_ZERO + d));
                    else if ($urandom_range(0, 1)) text_q.push_back(8'(CH_UA + d - 10));
                    else text_q.push_back(8'(CH_LA + d - 10));
                end
            end
            LF_BIN: begin
                if ($urandom_range(0, 7) == 0) text_q.push_back(CH_MINUS);
                text_q.push_back(CH_ZERO);
                text_q.push_back(CH_LB);
                ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 36)
                                                   : $urandom_range(0, 12);
                repeat (ndig) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
            end
            default: begin
                repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        // Corrupt: stray byte, upper-case mark, or cut short
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 2))
                0:       text_q[pos] = 8'($urandom_range(0, 255));
                1:       text_q[pos] = $urandom_range(0, 1) ? CH_UX : CH_UB;
                default: while (text_q.size() > pos + 1) void'(text_q.pop_back());
            endcase
        end
    endtask

    initial begin : stimulus
        int start_chars;
        sb = new();

        // Hold reset, then release
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone sign, bare prefix, negative binary, upper-case mark,
        // negative zero, positive wrap into the sign bit, bytes at both extremes
        send_string("-");
        send_string("0b");
        send_string("-0b1");
        send_string("0X1");
        send_string("-0");
        send_string("0x80000000");
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text();
        text_q.delete();
        text_q.push_back(8'h00);
        send_text();

        // Random literals; partway through, ask the receiver for the long hold-off
        start_chars = chars_sent;
        while (chars_sent - start_chars < RANDOM_CHARS) begin
            if (!hold_off_go && chars_sent - start_chars >= HOLD_OFF_AT) begin
                hold_off_go <= 1'b1;
            end
            make_literal();
            send_text();
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d characters in %0d literals: %0d valid, %0d hex, %0d binary",
                 chars_sent, sb.n_results, sb.n_valid, sb.n_hex, sb.n_bin);
        $display("%0d results overflowed; input back-pressure on %0d cycles; %0d mismatches",
                 sb.n_ovf, in_stalls, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/nlp_pkg.sv
hw/rtl/numeric_literal_parser_unit.sv
verif/numeric_literal_parser_unit_tb.sv
